// File: design/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg: shared types and constants of the Bezier curve sampler
// Command and status codes, Q0.16 constants.
// ----------------------------------------------------------------------------
package bcs_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam int COORD_W = 24;
  localparam int FRAC_W  = 16;
  localparam logic [FRAC_W-1:0] HALF_LSB = 16'h8000;

  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// File: design/bcs_divider.sv
// ----------------------------------------------------------------------------
// bcs_divider: restoring divider for t = (idx << 16) / sc
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcs_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num_hi,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot
);

  logic [16:0] rem_r, rem_nxt;
  logic [15:0] quot_r, quot_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] shifted;
  logic [17:0] diff;

  // shift one zero numerator bit in, trial subtract
  always_comb begin
    shifted  = {rem_r, 1'b0};
    diff     = shifted - {2'b00, den};
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num_hi};
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[17]) begin
        rem_nxt  = diff[16:0];
        quot_nxt = {quot_r[14:0], 1'b1};
      end else begin
        rem_nxt  = shifted[16:0];
        quot_nxt = {quot_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: design/bezier_curve_sampler_core.sv
// ----------------------------------------------------------------------------
// bezier_curve_sampler_core: de Casteljau Bezier curve evaluator
// Control point store, Q0.16 parameter divider and one shared lerp unit.
// ----------------------------------------------------------------------------
// Clear and append go from start through S_OUT to out_valid. Evaluate with
// two or more points runs the divider, then each X/Y interpolation pair
// (per coordinate: two reads, operand latch, multiply, write back) in
// S_RD, S_MUL and S_WR; a single point goes straight to S_FIN. The single
// shared multiplier and the one-port scratch memory serialize these
// steps. Each result appears for one cycle with out_valid and cannot be
// stalled; busy stays high through that cycle.
// ----------------------------------------------------------------------------
module bezier_curve_sampler_core #(
  parameter int MAX_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic [15:0] in_sample_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_sample_count,
  output logic        out_valid,
  output logic signed [23:0] out_curve_x,
  output logic signed [23:0] out_curve_y,
  output logic [1:0]  out_status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_MUL, S_WR, S_FIN, S_OUT
  } state_t;

  state_t state_r;

  // memories: control store and scratch, one entry per point, X and Y packed
  logic [47:0] ctrl_mem [MAX_POINTS];
  logic [47:0] scr_mem  [MAX_POINTS];

  logic [15:0]   sc_r;
  logic [CW-1:0] count_r;
  logic [15:0]   idx_r;
  logic [15:0]   t_r;
  logic [AW-1:0] j_r;
  logic [CW-1:0] lim_r;
  logic          lvl1_r;
  logic          ph_r;     // 0: read a, 1: read b
  logic          ysel_r;
  logic [47:0]   rd_r;
  logic signed [23:0] a_r, b_r;
  logic signed [40:0] prod_r;
  logic signed [23:0] resx_r;
  logic signed [23:0] res_x_r, res_y_r;
  logic [1:0]    stat_r;
  logic          div_start_r;
  logic          div_done;
  logic [15:0]   div_q;
  logic [15:0]   sc_eff;
  logic [15:0]   idx_clip;

  assign sc_eff   = (sc_r == 16'd0) ? 16'd1 : sc_r;
  assign idx_clip = (in_sample_index >= sc_eff) ? sc_eff - 16'd1 : in_sample_index;

  bcs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .num_hi(idx_r),
    .den(sc_eff), .done(div_done), .quot(div_q)
  );

  // shared lerp: a + floor(((b-a)*t + 0x8000) >> 16)
  logic signed [24:0] diff_w;
  logic signed [40:0] lerp_sum;
  logic signed [23:0] lerp_out;
  assign diff_w   = 25'(b_r) - 25'(a_r);
  assign lerp_sum = prod_r + 41'sd32768;
  assign lerp_out = a_r + 24'(lerp_sum >>> bcs_pkg::FRAC_W);

  // memory read address: current entry or next
  logic [AW-1:0] raddr;
  assign raddr = ph_r ? AW'(j_r + AW'(1)) : j_r;

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      rd_r <= lvl1_r ? ctrl_mem[raddr] : scr_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start && !busy &&
        bcs_pkg::cmd_t'(in_command) == bcs_pkg::CMD_APPEND &&
        count_r < CW'(MAX_POINTS)) begin
      ctrl_mem[count_r[AW-1:0]] <= {in_point_x, in_point_y};
    end
    if (state_r == S_WR && ysel_r) begin
      scr_mem[j_r] <= {resx_r, lerp_out};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sc_r        <= 16'd1;
      count_r     <= '0;
      div_start_r <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      out_valid   <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        sc_r <= cfg_sample_count;
      end
      case (state_r)
        S_IDLE: begin
          if (start && !busy) begin
            res_x_r <= '0;
            res_y_r <= '0;
            stat_r  <= bcs_pkg::ST_OK;
            state_r <= S_OUT;
            case (bcs_pkg::cmd_t'(in_command))
              bcs_pkg::CMD_CLEAR: count_r <= '0;
              bcs_pkg::CMD_APPEND: begin
                if (count_r >= CW'(MAX_POINTS)) stat_r <= bcs_pkg::ST_FULL;
                else count_r <= count_r + CW'(1);
              end
              bcs_pkg::CMD_EVAL: begin
                if (count_r == '0) begin
                  stat_r <= bcs_pkg::ST_EMPTY;
                end else begin
                  idx_r       <= idx_clip;
                  div_start_r <= 1'b1;
                  j_r         <= '0;
                  ph_r        <= 1'b0;
                  ysel_r      <= 1'b0;
                  lvl1_r      <= 1'b1;
                  lim_r       <= count_r - CW'(1);
                  state_r     <= (count_r == CW'(1)) ? S_FIN : S_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_r     <= div_q;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          // two reads: a then b; the b read lands as ph toggles back
          if (!ph_r) begin
            ph_r <= 1'b1;
          end else begin
            ph_r    <= 1'b0;
            state_r <= S_MUL;
          end
          if (ph_r) a_r <= ysel_r ? rd_r[23:0] : rd_r[47:24];
        end
        S_MUL: begin
          b_r     <= ysel_r ? rd_r[23:0] : rd_r[47:24];
          state_r <= S_WR;
          ph_r    <= 1'b1;
        end
        S_WR: begin
          if (ph_r) begin
            prod_r <= 41'(diff_w * $signed({1'b0, t_r}));
            ph_r   <= 1'b0;
          end else if (!ysel_r) begin
            resx_r  <= lerp_out;
            ysel_r  <= 1'b1;
            state_r <= S_RD;
          end else begin
            ysel_r <= 1'b0;
            if (CW'(j_r) + CW'(1) >= lim_r) begin
              j_r    <= '0;
              lvl1_r <= 1'b0;
              lim_r  <= lim_r - CW'(1);
              state_r <= (lim_r == CW'(1)) ? S_FIN : S_RD;
            end else begin
              j_r     <= j_r + AW'(1);
              state_r <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (lvl1_r) begin
            res_x_r <= ctrl_mem[0][47:24];
            res_y_r <= ctrl_mem[0][23:0];
          end else begin
            res_x_r <= scr_mem[0][47:24];
            res_y_r <= scr_mem[0][23:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // busy covers the output cycle so a new command waits for it
  assign busy        = (state_r != S_IDLE) || out_valid;
  assign cfg_ready   = !busy;
  assign out_curve_x = res_x_r;
  assign out_curve_y = res_y_r;
  assign out_status  = stat_r;

endmodule
